FILE: sv/scdec_pkg.sv
// ----------------------------------------------------------------------------
// scdec_pkg
// Shared codes, types and the layout table of the set-1 scancode decoder.
// ----------------------------------------------------------------------------
package scdec_pkg;

   localparam int CODE_WIDTH = 7;
   localparam int CHAR_WIDTH = 8;

   localparam logic [CODE_WIDTH-1:0] KEY_TAB    = 7'h0F;
   localparam logic [CODE_WIDTH-1:0] KEY_LSHIFT = 7'h2A;
   localparam logic [CODE_WIDTH-1:0] KEY_RSHIFT = 7'h36;

   localparam logic [CHAR_WIDTH-1:0] CHAR_NONE     = 8'h00;
   localparam logic [CHAR_WIDTH-1:0] CHAR_UNMAPPED = 8'h23;
   localparam logic [CHAR_WIDTH-1:0] CHAR_NEWLINE  = 8'h0A;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_A  = 8'h61;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_Z  = 8'h7A;
   localparam logic [CHAR_WIDTH-1:0] CASE_BIT      = 8'h20;

   // Modifier keys as they stand once the current item is applied
   typedef struct packed {
      logic shift_held;
      logic tab_held;
   } key_status_type;

   typedef struct packed {
      logic                  is_make;
      logic [CHAR_WIDTH-1:0] char_code;
      logic                  char_valid;
      logic                  space_before;
      logic                  next_terminal;
   } result_type;

   // Layout ROM; zero marks an unmapped key
   function automatic logic [CHAR_WIDTH-1:0] layout_rom(input logic [CODE_WIDTH-1:0] code);
      logic [CHAR_WIDTH-1:0] ch;
      unique case (code)
         7'h02: ch = 8'h31;
         7'h03: ch = 8'h32;
         7'h04: ch = 8'h33;
         7'h05: ch = 8'h34;
         7'h06: ch = 8'h35;
         7'h07: ch = 8'h36;
         7'h08: ch = 8'h37;
         7'h09: ch = 8'h38;
         7'h0A: ch = 8'h39;
         7'h0B: ch = 8'h30;
         7'h0C: ch = 8'h27;
         7'h0D: ch = 8'hA1;
         7'h10: ch = 8'h71;
         7'h11: ch = 8'h77;
         7'h12: ch = 8'h65;
         7'h13: ch = 8'h72;
         7'h14: ch = 8'h74;
         7'h15: ch = 8'h79;
         7'h16: ch = 8'h75;
         7'h17: ch = 8'h69;
         7'h18: ch = 8'h6F;
         7'h19: ch = 8'h70;
         7'h1A: ch = 8'h60;
         7'h1B: ch = 8'h2B;
         7'h1C: ch = 8'h0A;
         7'h1E: ch = 8'h61;
         7'h1F: ch = 8'h73;
         7'h20: ch = 8'h64;
         7'h21: ch = 8'h66;
         7'h22: ch = 8'h67;
         7'h23: ch = 8'h68;
         7'h24: ch = 8'h6A;
         7'h25: ch = 8'h6B;
         7'h26: ch = 8'h6C;
         7'h27: ch = 8'hF1;
         7'h29: ch = 8'hBA;
         7'h2B: ch = 8'hE7;
         7'h2C: ch = 8'h7A;
         7'h2D: ch = 8'h78;
         7'h2E: ch = 8'h63;
         7'h2F: ch = 8'h76;
         7'h30: ch = 8'h62;
         7'h31: ch = 8'h6E;
         7'h32: ch = 8'h6D;
         7'h33: ch = 8'h2C;
         7'h34: ch = 8'h2E;
         7'h35: ch = 8'h2D;
         7'h37: ch = 8'h2A;
         7'h39: ch = 8'h20;
         7'h47: ch = 8'h37;
         7'h48: ch = 8'h38;
         7'h49: ch = 8'h39;
         7'h4A: ch = 8'h2D;
         7'h4B: ch = 8'h34;
         7'h4C: ch = 8'h35;
         7'h4D: ch = 8'h36;
         7'h4E: ch = 8'h2B;
         7'h4F: ch = 8'h31;
         7'h50: ch = 8'h32;
         7'h51: ch = 8'h33;
         7'h52: ch = 8'h30;
         7'h56: ch = 8'h3C;
         default: ch = CHAR_NONE;
      endcase
      return ch;
   endfunction

endpackage

FILE: sv/scdec_keymap.sv
// ----------------------------------------------------------------------------
// scdec_keymap
// Pressed-key map, one flop per scancode, cleared at reset. Reports the
// modifier keys as they stand after the current item is applied.
// ----------------------------------------------------------------------------
module scdec_keymap (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                wr_en,
   input  logic [scdec_pkg::CODE_WIDTH-1:0]    code,
   input  logic                                make,
   output scdec_pkg::key_status_type           status
);

   localparam int NUM_KEYS = 1 << scdec_pkg::CODE_WIDTH;

   logic [NUM_KEYS-1:0] map_ff;
   logic [NUM_KEYS-1:0] map_in;

   always_comb begin
      map_in = map_ff;
      if (wr_en) begin
         map_in[code] = make;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff <= '0;
      end else begin
         map_ff <= map_in;
      end
   end

   // Look ahead through the write so a make of shift counts at once
   assign status.shift_held = map_in[scdec_pkg::KEY_LSHIFT] | map_in[scdec_pkg::KEY_RSHIFT];
   assign status.tab_held   = map_in[scdec_pkg::KEY_TAB];

endmodule

FILE: sv/scdec_char_decode.sv
// ----------------------------------------------------------------------------
// scdec_char_decode
// Table lookup, shift case folding and result flags for one keyboard byte.
// ----------------------------------------------------------------------------
module scdec_char_decode (
   input  logic [7:0]                 scan_byte,
   input  scdec_pkg::key_status_type  status,
   output scdec_pkg::result_type      result
);

   logic [scdec_pkg::CODE_WIDTH-1:0] code;
   logic [scdec_pkg::CHAR_WIDTH-1:0] rom_char;
   logic                             is_lower;

   assign code     = scan_byte[scdec_pkg::CODE_WIDTH-1:0];
   assign rom_char = scdec_pkg::layout_rom(code);
   assign is_lower = (rom_char >= scdec_pkg::CHAR_LOWER_A) &&
                     (rom_char <= scdec_pkg::CHAR_LOWER_Z);

   always_comb begin
      result = '0;
      if (!scan_byte[7]) begin
         result.is_make       = 1'b1;
         result.next_terminal = status.shift_held & status.tab_held;
         if (rom_char == scdec_pkg::CHAR_NONE) begin
            result.char_code = scdec_pkg::CHAR_UNMAPPED;
         end else begin
            result.char_valid   = 1'b1;
            result.space_before = (rom_char == scdec_pkg::CHAR_NEWLINE);
            // clear the case bit to uppercase a letter
            if (status.shift_held && is_lower) begin
               result.char_code = rom_char & ~scdec_pkg::CASE_BIT;
            end else begin
               result.char_code = rom_char;
            end
         end
      end
   end

endmodule

FILE: sv/scancode_to_ascii_decoder_unit.sv
// ----------------------------------------------------------------------------
// scancode_to_ascii_decoder_unit
// Set-1 keyboard byte to character decoder with a pressed-key map.
// ----------------------------------------------------------------------------
//  channel | direction | payload                                   | handshake
//  req     | in        | scan_byte                                 | req_valid/req_ready
//  rsp     | out       | is_make, char_code, char_valid,           | rsp_valid/rsp_ready
//          |           | space_before, next_terminal               |
//
//  One item per cycle unless the output stalls: each accepted byte updates the
//  key map and yields its result in the output register on the next cycle.
//  Reset clears the key map and the output valid.
//  A stalled result holds; a new byte is still taken in the cycle the held
//  result is taken.
// ----------------------------------------------------------------------------
module scancode_to_ascii_decoder_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_scan_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_is_make,
   output logic [7:0] rsp_char_code,
   output logic       rsp_char_valid,
   output logic       rsp_space_before,
   output logic       rsp_next_terminal
);

   scdec_pkg::key_status_type status;
   scdec_pkg::result_type     result;
   scdec_pkg::result_type     result_ff;
   logic                      valid_ff;
   logic                      valid_in;
   logic                      accept;

   assign req_ready = !valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign valid_in  = accept || (valid_ff && !rsp_ready);

   scdec_keymap u_keymap (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (accept),
      .code   (req_scan_byte[scdec_pkg::CODE_WIDTH-1:0]),
      .make   (!req_scan_byte[7]),
      .status (status)
   );

   scdec_char_decode u_char_decode (
      .scan_byte (req_scan_byte),
      .status    (status),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff <= result;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_is_make       = result_ff.is_make;
   assign rsp_char_code     = result_ff.char_code;
   assign rsp_char_valid    = result_ff.char_valid;
   assign rsp_space_before  = result_ff.space_before;
   assign rsp_next_terminal = result_ff.next_terminal;

endmodule
